// ===== hdl/lpg_pkg.sv =====
// Shared types and constants for the LED pattern generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpg_pkg;

  // Command codes
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_MODE   = 2'd1;
  localparam logic [1:0] CMD_ENABLE = 2'd2;

  // Mode codes
  localparam logic [3:0] MODE_OFF    = 4'd0;
  localparam logic [3:0] MODE_ON     = 4'd1;
  localparam logic [3:0] MODE_TOGGLE = 4'd2;
  localparam logic [3:0] MODE_BLINK5 = 4'd3;
  localparam logic [3:0] MODE_BLINK1 = 4'd4;
  localparam logic [3:0] MODE_B1HZ   = 4'd5;
  localparam logic [3:0] MODE_F1HZ   = 4'd6;
  localparam logic [3:0] MODE_B3HZ   = 4'd7;
  localparam logic [3:0] MODE_F3HZ   = 4'd8;

  // Segment lengths in ticks
  localparam logic [9:0] SLOW_STEP_TICKS = 10'd500;
  localparam logic [9:0] BEAT_ON_TICKS   = 10'd800;
  localparam logic [9:0] BEAT_OFF_TICKS  = 10'd200;
  localparam logic [9:0] FAST_ON_TICKS   = 10'd267;
  localparam logic [9:0] FAST_OFF_TICKS  = 10'd100;

  // Segment counts per unit
  localparam logic [3:0] BURST_COUNT     = 4'd5;
  localparam logic [3:0] BURST_SEGMENTS  = 4'(2 * BURST_COUNT);
  localparam logic [3:0] PAIR_SEGMENTS   = 4'd2;
  localparam logic [3:0] FAST_SEGMENTS   = 4'd6;
  localparam logic [3:0] SINGLE_SEGMENT  = 4'd1;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] mode_value;
    logic       enable_value;
  } in_word_t;

  typedef struct packed {
    logic       led_level;
    logic [3:0] mode_now;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/led_pattern_generator_unit.sv =====
// Top level of the LED pattern generator: pattern core plus result buffer.
// Depends on lpg_pkg, lpg_core and lpg_out_buf.
//
//   channel | direction | handshake                | word
//   --------+-----------+--------------------------+-------------------------------------
//   in      | into      | in_valid / in_stall      | in_word  (command, mode_value, enable)
//   out     | out of    | out_valid / out_stall    | out_word (led_level, mode_now)
//
// One word per cycle while in_stall is low: an accepted word updates the pattern state in
// the same cycle and its result is registered, in the result register or the skid stage.
// The result register and a one-entry skid stage set the rate: in_stall rises only
// when both hold words, i.e. once a word is taken while the held result is stalled.
// rst (synchronous, active high) clears the buffers and restores the reset state:
// mode off, enable on, LED low, next tick starting a fresh pattern unit.
`default_nettype none

module led_pattern_generator_unit
  import lpg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  logic      accept;
  logic      buf_full;
  out_word_t result;

  // input is held off only while the skid stage is occupied
  assign in_stall = buf_full;
  assign accept   = in_valid & ~buf_full;

  lpg_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_word),
    .result (result)
  );

  lpg_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== hdl/lpg_core.sv =====
// Pattern state registers and the single-pass update for one input word.
// Depends on lpg_pkg.
`default_nettype none

module lpg_core
  import lpg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire in_word_t  item,
  output out_word_t      result
);

  logic [3:0] mode_reg, mode_reg_next;
  logic [3:0] saved_mode, saved_mode_next;
  logic       enable_reg, enable_reg_next;
  logic       level_reg, level_reg_next;
  logic [3:0] unit_mode, unit_mode_next;
  logic [9:0] segment_timer, segment_timer_next;
  logic [3:0] segment_index, segment_index_next;

  function automatic logic [3:0] seg_count(input logic [3:0] m);
    logic [3:0] n;
    case (m) inside
      MODE_BLINK5:                          n = BURST_SEGMENTS;
      MODE_BLINK1, MODE_B1HZ, MODE_F1HZ:    n = PAIR_SEGMENTS;
      MODE_B3HZ, MODE_F3HZ:                 n = FAST_SEGMENTS;
      default:                              n = SINGLE_SEGMENT;
    endcase
    return n;
  endfunction

  function automatic logic [9:0] seg_length(input logic [3:0] m, input logic first);
    logic [9:0] len;
    case (m) inside
      MODE_B1HZ, MODE_F1HZ: len = first ? BEAT_ON_TICKS : BEAT_OFF_TICKS;
      MODE_B3HZ, MODE_F3HZ: len = first ? FAST_ON_TICKS : FAST_OFF_TICKS;
      default:              len = SLOW_STEP_TICKS;
    endcase
    return (len == 10'd0) ? 10'd1 : len;
  endfunction

  function automatic logic seg_level(input logic [3:0] m, input logic first,
                                     input logic cur);
    logic lv;
    case (m) inside
      MODE_OFF:                                         lv = 1'b0;
      MODE_ON:                                          lv = 1'b1;
      MODE_TOGGLE:                                      lv = cur;
      MODE_BLINK5, MODE_BLINK1, MODE_B1HZ, MODE_B3HZ:   lv = first;
      MODE_F1HZ, MODE_F3HZ:                             lv = ~first;
      default:                                          lv = 1'b0;
    endcase
    return lv;
  endfunction

  always_comb begin
    logic       first;
    logic [3:0] idx_inc;
    logic [9:0] timer_load;

    mode_reg_next      = mode_reg;
    saved_mode_next    = saved_mode;
    enable_reg_next    = enable_reg;
    level_reg_next     = level_reg;
    unit_mode_next     = unit_mode;
    segment_timer_next = segment_timer;
    segment_index_next = segment_index;
    first              = ~segment_index[0];
    idx_inc            = segment_index + 4'd1;
    timer_load         = segment_timer;

    if (accept) begin
      case (item.command)
        CMD_TICK: begin
          if (segment_timer == 10'd0) begin
            // unit start: sample enable and mode
            if (segment_index == 4'd0) begin
              if (!enable_reg) begin
                unit_mode_next = MODE_OFF;
              end else begin
                unit_mode_next = mode_reg;
                case (mode_reg) inside
                  MODE_TOGGLE: begin
                    level_reg_next = ~level_reg;
                    mode_reg_next  = level_reg ? MODE_OFF : MODE_ON;
                  end
                  MODE_BLINK5, MODE_BLINK1: ;
                  MODE_OFF, MODE_ON, MODE_B1HZ, MODE_F1HZ, MODE_B3HZ, MODE_F3HZ:
                    saved_mode_next = mode_reg;
                  default: unit_mode_next = MODE_OFF;
                endcase
              end
            end
            // segment start
            level_reg_next = seg_level(unit_mode_next, first, level_reg_next);
            timer_load     = seg_length(unit_mode_next, first);
          end
          segment_timer_next = timer_load - 10'd1;
          if (segment_timer_next == 10'd0) begin
            segment_index_next = idx_inc;
            if (idx_inc >= seg_count(unit_mode_next)) begin
              segment_index_next = 4'd0;
              // bursts hand back to the last steady mode
              if (unit_mode_next == MODE_BLINK5 || unit_mode_next == MODE_BLINK1) begin
                mode_reg_next = saved_mode_next;
              end
            end
          end
        end
        CMD_MODE: begin
          if (item.mode_value <= MODE_F3HZ) begin
            mode_reg_next = item.mode_value;
          end
        end
        CMD_ENABLE: enable_reg_next = item.enable_value;
        default: ;
      endcase
    end

    result.led_level = level_reg_next;
    result.mode_now  = mode_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_OFF;
      saved_mode    <= MODE_OFF;
      enable_reg    <= 1'b1;
      level_reg     <= 1'b0;
      unit_mode     <= MODE_OFF;
      segment_timer <= 10'd0;
      segment_index <= 4'd0;
    end else begin
      mode_reg      <= mode_reg_next;
      saved_mode    <= saved_mode_next;
      enable_reg    <= enable_reg_next;
      level_reg     <= level_reg_next;
      unit_mode     <= unit_mode_next;
      segment_timer <= segment_timer_next;
      segment_index <= segment_index_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lpg_out_buf.sv =====
// Result register with a skid stage, so input and output stalls stay apart.
// Depends on lpg_pkg.
`default_nettype none

module lpg_out_buf
  import lpg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire out_word_t push_word,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  logic      main_valid;
  out_word_t main_word;
  logic      skid_valid;
  out_word_t skid_word;
  logic      pop;

  assign pop       = main_valid & ~out_stall;
  assign full      = skid_valid;
  assign out_valid = main_valid;
  assign out_word  = main_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      main_word <= skid_valid ? skid_word : push_word;
    end else if (push) begin
      if (!main_valid) begin
        main_word <= push_word;
      end else begin
        skid_word <= push_word;
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/lpg_pattern_checker.sv =====
// Checker for the LED pattern generator: watches both channels, predicts each result
// word and compares it field by field. Depends on lpg_pkg.
module lpg_pattern_checker
  import lpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  output int        mismatch_count,
  output int        awaited_words,
  output int        checked_words
);

  localparam int REPORT_LIMIT = 200;

  // predicted pattern state
  logic [3:0] mode_q;
  logic [3:0] saved_q;
  logic       enable_q;
  logic       level_q;
  logic [3:0] unit_q;
  logic [9:0] seg_timer;
  logic [3:0] seg_idx;

  out_word_t pending_led_states[$];
  out_word_t want;
  int        reported;

  initial begin
    mismatch_count = 0;
    awaited_words  = 0;
    checked_words  = 0;
    reported       = 0;
  end

  function automatic logic [3:0] unit_segments(input logic [3:0] m);
    case (m)
      MODE_BLINK5:                       return BURST_SEGMENTS;
      MODE_BLINK1, MODE_B1HZ, MODE_F1HZ: return PAIR_SEGMENTS;
      MODE_B3HZ, MODE_F3HZ:              return FAST_SEGMENTS;
      default:                           return SINGLE_SEGMENT;
    endcase
  endfunction

  function automatic logic [9:0] segment_ticks(input logic [3:0] m, input logic [3:0] idx);
    case (m)
      MODE_B1HZ, MODE_F1HZ: return idx[0] ? BEAT_OFF_TICKS : BEAT_ON_TICKS;
      MODE_B3HZ, MODE_F3HZ: return idx[0] ? FAST_OFF_TICKS : FAST_ON_TICKS;
      default:              return SLOW_STEP_TICKS;
    endcase
  endfunction

  task automatic clear_pattern();
    mode_q    = MODE_OFF;
    saved_q   = MODE_OFF;
    enable_q  = 1'b1;
    level_q   = 1'b0;
    unit_q    = MODE_OFF;
    seg_timer = '0;
    seg_idx   = '0;
  endtask

  task automatic run_tick();
    if (seg_timer == '0) begin
      // new unit: sample mode and enable
      if (seg_idx == '0) begin
        if (!enable_q) begin
          unit_q = MODE_OFF;
        end else begin
          unit_q = mode_q;
          case (unit_q)
            MODE_TOGGLE: begin
              level_q = ~level_q;
              mode_q  = level_q ? MODE_ON : MODE_OFF;
            end
            MODE_BLINK5, MODE_BLINK1: begin
            end
            MODE_OFF, MODE_ON, MODE_B1HZ, MODE_F1HZ, MODE_B3HZ, MODE_F3HZ: begin
              saved_q = unit_q;
            end
            default: unit_q = MODE_OFF;
          endcase
        end
      end
      case (unit_q)
        MODE_OFF:    level_q = 1'b0;
        MODE_ON:     level_q = 1'b1;
        MODE_TOGGLE: begin
        end
        MODE_BLINK5, MODE_BLINK1, MODE_B1HZ, MODE_B3HZ: level_q = ~seg_idx[0];
        MODE_F1HZ, MODE_F3HZ: level_q = seg_idx[0];
        default:     level_q = 1'b0;
      endcase
      seg_timer = segment_ticks(unit_q, seg_idx);
    end
    seg_timer = seg_timer - 10'd1;
    if (seg_timer == '0) begin
      seg_idx = seg_idx + 4'd1;
      if (seg_idx >= unit_segments(unit_q)) begin
        seg_idx = '0;
        // bursts restore the last steady mode
        if (unit_q == MODE_BLINK5 || unit_q == MODE_BLINK1) mode_q = saved_q;
      end
    end
  endtask

  task automatic advance_pattern(input in_word_t w);
    out_word_t r;
    case (w.command)
      CMD_TICK:   run_tick();
      CMD_MODE:   if (w.mode_value <= MODE_F3HZ) mode_q = w.mode_value;
      CMD_ENABLE: enable_q = w.enable_value;
      default: begin
      end
    endcase
    r.led_level = level_q;
    r.mode_now  = mode_q;
    pending_led_states.push_back(r);
  endtask

  task automatic note_mismatch(input string what, input int exp_v, input int got_v);
    mismatch_count++;
    if (reported < REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
    else if (reported == REPORT_LIMIT)
      $display("%0t: further mismatches not reported", $time);
    reported++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_pattern();
      pending_led_states.delete();
    end else begin
      // a result never belongs to a word taken at the same edge, so pop first
      if (out_valid && !out_stall) begin
        if (pending_led_states.size() == 0) begin
          note_mismatch("unexpected result word, led_level", -1, out_word.led_level);
        end else begin
          want = pending_led_states.pop_front();
          checked_words++;
          if (out_word.led_level !== want.led_level)
            note_mismatch("led_level", want.led_level, out_word.led_level);
          if (out_word.mode_now !== want.mode_now)
            note_mismatch("mode_now", want.mode_now, out_word.mode_now);
        end
      end
      if (in_valid && !in_stall) advance_pattern(in_word);
    end
    awaited_words = pending_led_states.size();
  end

endmodule

// ===== dv/led_pattern_generator_unit_tb.sv =====
// Testbench top for the LED pattern generator: clock, reset, stimulus and verdict.
// Depends on lpg_pkg, led_pattern_generator_unit and lpg_pattern_checker.
module led_pattern_generator_unit_tb;
  import lpg_pkg::*;

  // command code the block has no use for; must leave the state alone
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int PHASES          = 4;
  localparam int EVENTS_PER_PHASE = 25;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int mismatch_count;
  int awaited_words;
  int checked_words;

  // idling controls, in percent of cycles
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  // stimulus tallies for the summary
  int n_ticks  = 0;
  int n_modes  = 0;
  int n_enable = 0;
  int n_other  = 0;

  always #2 clk = ~clk;

  led_pattern_generator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  lpg_pattern_checker led_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .mismatch_count (mismatch_count),
    .awaited_words  (awaited_words),
    .checked_words  (checked_words)
  );

  // Receiver side: stall drawn afresh every falling edge, held low in reset.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic in_word_t make_word(input logic [1:0] cmd, input logic [3:0] mv,
                                         input logic en);
    in_word_t w;
    w.command      = cmd;
    w.mode_value   = mv;
    w.enable_value = en;
    return w;
  endfunction

  // Hand one word to the block. Called just after a falling edge; returns just after
  // the falling edge that follows acceptance. in_stall only moves at rising edges, so
  // it is read after the falling edge, where it already holds its value for the next
  // rising edge. Valid is only ever assigned once per edge, so a back-to-back word
  // keeps it high with no glitch.
  task automatic push_word(input in_word_t w);
    logic stalled;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    stalled = in_stall;
    while (stalled) begin
      @(negedge clk);
      stalled = in_stall;
    end
    @(posedge clk);
    case (w.command)
      CMD_TICK:   n_ticks++;
      CMD_MODE:   n_modes++;
      CMD_ENABLE: n_enable++;
      default:    n_other++;
    endcase
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (awaited_words != 0) @(negedge clk);
  endtask

  // One random event: a register write (or a stray command) followed by a run of
  // ticks. Ticks carry random junk in the unused fields. Runs are mostly short so
  // writes land all over a unit, with the odd long one to move a unit along.
  task automatic random_event();
    int       r;
    int       run;
    in_word_t w;
    r = $urandom_range(99);
    if (r < 55) begin
      // mostly legal modes, now and then an out-of-range write
      if ($urandom_range(9) == 0)
        w = make_word(CMD_MODE, 4'($urandom_range(15, 9)), 1'($urandom));
      else
        w = make_word(CMD_MODE, 4'($urandom_range(8)), 1'($urandom));
    end else if (r < 85) begin
      // bias towards enabled so patterns actually run
      w = make_word(CMD_ENABLE, 4'($urandom), 1'($urandom_range(99) < 85));
    end else begin
      w = make_word(CMD_UNUSED, 4'($urandom), 1'($urandom));
    end
    push_word(w);
    run = ($urandom_range(24) == 0) ? $urandom_range(150, 50) : $urandom_range(12);
    repeat (run) push_word(make_word(CMD_TICK, 4'($urandom), 1'($urandom)));
  endtask

  // Watchdog: a healthy run finishes far sooner.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int idle_tab[PHASES];
    int stall_tab[PHASES];
    idle_tab  = '{0, 75, 0, 6};
    stall_tab = '{0, 0, 75, 6};

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening, no idling. Units only start every few hundred ticks, so
    // these mostly prove out register writes and the ignored cases.
    push_word(make_word(CMD_UNUSED, 4'hF, 1'b1));      // stray command: state reported only
    push_word(make_word(CMD_TICK, 4'hF, 1'b0));        // first tick opens an off unit
    push_word(make_word(CMD_MODE, 4'd9, 1'b0));        // just past the last mode: ignored
    push_word(make_word(CMD_MODE, 4'hF, 1'b1));        // top of range: ignored
    for (int m = 0; m <= 8; m++)
      push_word(make_word(CMD_MODE, 4'(m), 1'(m)));
    push_word(make_word(CMD_ENABLE, 4'h0, 1'b0));      // disable
    push_word(make_word(CMD_TICK, 4'h0, 1'b1));
    push_word(make_word(CMD_ENABLE, 4'hF, 1'b1));      // enable again
    push_word(make_word(CMD_MODE, MODE_TOGGLE, 1'b0));
    push_word(make_word(CMD_TICK, 4'hA, 1'b1));
    push_word(make_word(CMD_TICK, 4'h5, 1'b0));
    drain_results();

    // Random phases with differing idle patterns; drain between them so the
    // sender sits idle with nothing in flight at least once.
    for (int p = 0; p < PHASES; p++) begin
      sender_idle_pct = idle_tab[p];
      recv_stall_pct  = stall_tab[p];
      repeat (EVENTS_PER_PHASE) random_event();
      drain_results();
    end

    // let any stray result word surface before judging
    recv_stall_pct = 0;
    repeat (16) @(negedge clk);

    $display("Drove %0d ticks, %0d mode writes, %0d enable writes, %0d stray commands",
             n_ticks, n_modes, n_enable, n_other);
    $display("across %0d idle/stall phases; %0d result words checked",
             PHASES, checked_words);
    if (mismatch_count == 0 && awaited_words == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
